// File: src/srsg_pkg.sv
// ----------------------------------------------------------------------------
// srsg_pkg: shared types and constants
// Register indexes, field widths, stage records and the size clamp used by
// the counter and position logic of the serpentine scan generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int SIZE_W    = 11;              // columns_per_row / rows_per_frame
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam int POS_W     = 16;
  localparam int SAMPLE_W  = 10;
  localparam int STEP_W    = 8;
  localparam int LASER_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_PER_ROW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_FRAME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LASER_CHOICE    = 3'd6;

  localparam logic [LASER_W-1:0] LASER_MAX_CODE = 8'd3;

  // one step as captured at the input register
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    col;
    logic                row_odd;   // row parity before the step
    logic                last;      // last column of the row
    logic [CNT_W-1:0]    row;       // row index after the step
  } step_t;

  // one finished result
  typedef struct packed {
    logic [POS_W-1:0]    x_position;
    logic                x_drive_valid;
    logic [1:0]          laser_drive;
    logic [SAMPLE_W-1:0] sample_out;
    logic [CNT_W-1:0]    column;
    logic                row_end;
    logic [POS_W-1:0]    y_position;
    logic                y_drive_valid;
    logic [CNT_W-1:0]    row;
  } result_t;

  // zero acts as one, anything above MAX_STEPS saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_STEPS)) begin
      r = SIZE_W'(MAX_STEPS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: src/srsg_counter.sv
// ----------------------------------------------------------------------------
// srsg_counter: column and row counters
// Holds the scan position, advances it per accepted step and builds the
// record that goes into the input register.
// ----------------------------------------------------------------------------
module srsg_counter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  logic                                advance,
  input  logic [srsg_pkg::SIZE_W-1:0]         cols,
  input  logic [srsg_pkg::SIZE_W-1:0]         rows,
  input  logic [srsg_pkg::SAMPLE_W-1:0]       sample,
  output srsg_pkg::step_t                     step
);

  logic [srsg_pkg::CNT_W-1:0] col_r, col_nxt;
  logic [srsg_pkg::CNT_W-1:0] row_r, row_nxt;
  logic [srsg_pkg::SIZE_W-1:0] col_inc, row_inc;
  logic                        last;
  logic [srsg_pkg::CNT_W-1:0]  row_wrap;

  assign col_inc  = srsg_pkg::SIZE_W'(col_r) + srsg_pkg::SIZE_W'(1);
  assign row_inc  = srsg_pkg::SIZE_W'(row_r) + srsg_pkg::SIZE_W'(1);
  assign last     = (col_inc >= cols);
  assign row_wrap = (row_inc >= rows) ? '0 : row_inc[srsg_pkg::CNT_W-1:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = row_wrap;
      end else begin
        col_nxt = col_inc[srsg_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    step.sample  = sample;
    step.col     = col_r;
    step.row_odd = row_r[0];
    step.last    = last;
    step.row     = last ? row_wrap : row_r;
  end

endmodule

// File: src/srsg_calc.sv
// ----------------------------------------------------------------------------
// srsg_calc: drive position and laser select
// Turns a registered step into x/y drive values and the laser code.
// ----------------------------------------------------------------------------
module srsg_calc (
  input  srsg_pkg::step_t                     step,
  input  logic [srsg_pkg::SIZE_W-1:0]         cols,
  input  logic [srsg_pkg::SIZE_W-1:0]         rows,
  input  logic [srsg_pkg::POS_W-1:0]          x_center,
  input  logic [srsg_pkg::POS_W-1:0]          y_center,
  input  logic [srsg_pkg::STEP_W-1:0]         step_size,
  input  logic                                scan_enable,
  input  logic [srsg_pkg::LASER_W-1:0]        laser_choice,
  output srsg_pkg::result_t                   res
);

  localparam int PROD_W = srsg_pkg::POS_W + srsg_pkg::STEP_W;

  // (idx - half) * step, modulo 2^16
  function automatic logic [srsg_pkg::POS_W-1:0] offset_of(
    input logic [srsg_pkg::CNT_W-1:0]  idx,
    input logic [srsg_pkg::SIZE_W-2:0] half,
    input logic [srsg_pkg::STEP_W-1:0] stp
  );
    logic [srsg_pkg::POS_W-1:0] d;
    logic [PROD_W-1:0]          p;
    d = srsg_pkg::POS_W'(idx) - srsg_pkg::POS_W'(half);
    p = PROD_W'(d) * PROD_W'(stp);
    return p[srsg_pkg::POS_W-1:0];
  endfunction

  logic [srsg_pkg::POS_W-1:0] x_off, y_off;

  assign x_off = offset_of(step.col, cols[srsg_pkg::SIZE_W-1:1], step_size);
  assign y_off = offset_of(step.row, rows[srsg_pkg::SIZE_W-1:1], step_size);

  always_comb begin
    res.x_position    = step.row_odd ? (x_center - x_off) : (x_center + x_off);
    res.x_drive_valid = scan_enable;
    // laser only in the upper half of each group of eight columns
    if (step.col[2] && (laser_choice <= srsg_pkg::LASER_MAX_CODE)) begin
      res.laser_drive = laser_choice[1:0];
    end else begin
      res.laser_drive = 2'd0;
    end
    res.sample_out    = step.sample;
    res.column        = step.col;
    res.row_end       = step.last;
    res.y_position    = step.last ? (y_center + y_off) : '0;
    res.y_drive_valid = step.last & scan_enable;
    res.row           = step.row;
  end

endmodule

// File: src/serpentine_raster_scan_generator_core.sv
// ----------------------------------------------------------------------------
// serpentine_raster_scan_generator_core: serpentine scan position generator
// Per x-step tick, emits scanner drive positions, laser select and the echoed
// photodiode sample while walking a back-and-forth raster.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_sample): one request per x step,
//   carrying the photodiode reading for that step.
//   Result channel (out_valid / out_stall / out_*): one request per input, in
//   order: x drive, laser select, sample echo, column, row-end flag, y drive, row.
//   Config port (cfg_we / cfg_index / cfg_wdata): write-only, only while idle;
//   a write to columns_per_row or rows_per_frame restarts at column 0, row 0.
//   Pipeline: a taken request passes the input register, then the result
//   register, before it shows on the result port.
//   Throughput: one request per cycle while the receiver does not stall; the
//   two-register pipeline sets this, with one multiply-add per axis between them.
//   Reset: counters go to zero, registers to their defaults, pipeline empty.
//   Receiver stall: the result holds; one more request is taken into the
//   input register, after which in_stall rises until the result drains.
// ----------------------------------------------------------------------------
module serpentine_raster_scan_generator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // config
  input  logic                                cfg_we,
  input  logic [srsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srsg_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srsg_pkg::SAMPLE_W-1:0]       in_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [srsg_pkg::POS_W-1:0]          out_x_position,
  output logic                                out_x_drive_valid,
  output logic [1:0]                          out_laser_drive,
  output logic [srsg_pkg::SAMPLE_W-1:0]       out_sample_out,
  output logic [srsg_pkg::CNT_W-1:0]          out_column,
  output logic                                out_row_end,
  output logic [srsg_pkg::POS_W-1:0]          out_y_position,
  output logic                                out_y_drive_valid,
  output logic [srsg_pkg::CNT_W-1:0]          out_row
);

  // ---------------- config registers ----------------
  logic [srsg_pkg::SIZE_W-1:0]  columns_per_row_r;
  logic [srsg_pkg::SIZE_W-1:0]  rows_per_frame_r;
  logic [srsg_pkg::POS_W-1:0]   x_center_r;
  logic [srsg_pkg::POS_W-1:0]   y_center_r;
  logic [srsg_pkg::STEP_W-1:0]  step_size_r;
  logic                         scan_enable_r;
  logic [srsg_pkg::LASER_W-1:0] laser_choice_r;

  logic size_write;   // any write to a size register restarts the scan

  assign size_write = cfg_we && ((cfg_index == srsg_pkg::REG_COLUMNS_PER_ROW) ||
                                 (cfg_index == srsg_pkg::REG_ROWS_PER_FRAME));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_per_row_r <= srsg_pkg::SIZE_W'(216);
      rows_per_frame_r  <= srsg_pkg::SIZE_W'(216);
      x_center_r        <= srsg_pkg::POS_W'(2170);
      y_center_r        <= srsg_pkg::POS_W'(2050);
      step_size_r       <= srsg_pkg::STEP_W'(8);
      scan_enable_r     <= 1'b0;
      laser_choice_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        srsg_pkg::REG_COLUMNS_PER_ROW: begin
          columns_per_row_r <= cfg_wdata[srsg_pkg::SIZE_W-1:0];
        end
        srsg_pkg::REG_ROWS_PER_FRAME: begin
          rows_per_frame_r <= cfg_wdata[srsg_pkg::SIZE_W-1:0];
        end
        srsg_pkg::REG_X_CENTER: begin
          x_center_r <= cfg_wdata;
        end
        srsg_pkg::REG_Y_CENTER: begin
          y_center_r <= cfg_wdata;
        end
        srsg_pkg::REG_STEP_SIZE: begin
          step_size_r <= cfg_wdata[srsg_pkg::STEP_W-1:0];
        end
        srsg_pkg::REG_SCAN_ENABLE: begin
          scan_enable_r <= cfg_wdata[0];
        end
        srsg_pkg::REG_LASER_CHOICE: begin
          laser_choice_r <= cfg_wdata[srsg_pkg::LASER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamped sizes: zero acts as one, large values saturate
  logic [srsg_pkg::SIZE_W-1:0] cols_eff, rows_eff;
  assign cols_eff = srsg_pkg::eff_size(columns_per_row_r);
  assign rows_eff = srsg_pkg::eff_size(rows_per_frame_r);

  // ---------------- handshake ----------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s2_take;      // result register free or draining this cycle
  logic s1_adv;       // input register moves into the result register
  logic in_accept;

  assign s2_take   = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && s2_take;
  assign in_stall  = s1_valid_r && !s2_take;
  assign in_accept = in_valid && !in_stall;

  // ---------------- counters / input register ----------------
  srsg_pkg::step_t step_in;
  srsg_pkg::step_t s1_r;

  srsg_counter u_counter (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (size_write),
    .advance (in_accept),
    .cols    (cols_eff),
    .rows    (rows_eff),
    .sample  (in_sample),
    .step    (step_in)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= step_in;
    end
  end

  // ---------------- position math / result register ----------------
  srsg_pkg::result_t res;
  srsg_pkg::result_t out_r;

  srsg_calc u_calc (
    .step         (s1_r),
    .cols         (cols_eff),
    .rows         (rows_eff),
    .x_center     (x_center_r),
    .y_center     (y_center_r),
    .step_size    (step_size_r),
    .scan_enable  (scan_enable_r),
    .laser_choice (laser_choice_r),
    .res          (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x_position    = out_r.x_position;
  assign out_x_drive_valid = out_r.x_drive_valid;
  assign out_laser_drive   = out_r.laser_drive;
  assign out_sample_out    = out_r.sample_out;
  assign out_column        = out_r.column;
  assign out_row_end       = out_r.row_end;
  assign out_y_position    = out_r.y_position;
  assign out_y_drive_valid = out_r.y_drive_valid;
  assign out_row           = out_r.row;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: serpentine raster scan generator check
// Drives x-step requests with random photodiode samples, predicts every
// result with an independent raster model (counters, mirrored x, y on row
// end, laser gating) and checks each result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // block ports
  // --------------------------------------------------------------------------
  logic                           cfg_we;
  logic [srsg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [srsg_pkg::CFG_DAT_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [srsg_pkg::SAMPLE_W-1:0]  in_sample;
  logic                           out_valid;
  logic                           out_stall;
  logic [srsg_pkg::POS_W-1:0]     out_x_position;
  logic                           out_x_drive_valid;
  logic [1:0]                     out_laser_drive;
  logic [srsg_pkg::SAMPLE_W-1:0]  out_sample_out;
  logic [srsg_pkg::CNT_W-1:0]     out_column;
  logic                           out_row_end;
  logic [srsg_pkg::POS_W-1:0]     out_y_position;
  logic                           out_y_drive_valid;
  logic [srsg_pkg::CNT_W-1:0]     out_row;

  serpentine_raster_scan_generator_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x_position    (out_x_position),
    .out_x_drive_valid (out_x_drive_valid),
    .out_laser_drive   (out_laser_drive),
    .out_sample_out    (out_sample_out),
    .out_column        (out_column),
    .out_row_end       (out_row_end),
    .out_y_position    (out_y_position),
    .out_y_drive_valid (out_y_drive_valid),
    .out_row           (out_row)
  );

  // --------------------------------------------------------------------------
  // raster model: register shadows and scan counters
  // --------------------------------------------------------------------------
  logic [srsg_pkg::SIZE_W-1:0]  cols_set;
  logic [srsg_pkg::SIZE_W-1:0]  rows_set;
  logic [srsg_pkg::POS_W-1:0]   x_mid;
  logic [srsg_pkg::POS_W-1:0]   y_mid;
  logic [srsg_pkg::STEP_W-1:0]  step_units;
  logic                         scan_on;
  logic [srsg_pkg::LASER_W-1:0] laser_sel;
  logic [srsg_pkg::CNT_W-1:0]   col_at;
  logic [srsg_pkg::CNT_W-1:0]   row_at;

  srsg_pkg::result_t raster_due[$];   // predicted results, oldest first

  int samples_sent;
  int results_seen;
  int row_ends_seen;
  int mismatch_count;

  // idle control: sender gap limit, receiver stall limit, pending stalls
  int tx_max;
  int rx_max;
  int rx_wait;             // owned by the sink
  int rx_hold;             // length of a long receiver hold-off
  int rx_hold_id;          // bumped to start one hold-off

  // effective size: zero behaves as one, large values clamp to MAX_STEPS
  function automatic int span_of(input logic [srsg_pkg::SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > srsg_pkg::MAX_STEPS) return srsg_pkg::MAX_STEPS;
    return int'(v);
  endfunction

  // (idx - size/2) * step, all mod 2^16
  function automatic logic [srsg_pkg::POS_W-1:0] step_offset(
    input logic [srsg_pkg::CNT_W-1:0] idx,
    input int                         size
  );
    logic [srsg_pkg::POS_W-1:0] d;
    logic [31:0]                p;
    d = srsg_pkg::POS_W'(int'(idx) - size / 2);
    p = 32'(d) * 32'(step_units);
    return p[srsg_pkg::POS_W-1:0];
  endfunction

  // one x step: returns the result and advances the counters
  function automatic srsg_pkg::result_t advance_raster(
    input logic [srsg_pkg::SAMPLE_W-1:0] smp
  );
    srsg_pkg::result_t          r;
    int                         cols;
    int                         rows;
    int                         next_row;
    logic [srsg_pkg::POS_W-1:0] off;
    cols = span_of(cols_set);
    rows = span_of(rows_set);
    off  = step_offset(col_at, cols);
    // odd rows run the other way
    r.x_position    = row_at[0] ? x_mid - off : x_mid + off;
    r.x_drive_valid = scan_on;
    // laser is dark on the first half of every group of eight columns
    r.laser_drive   = (col_at[2:0] >= 3'd4 && laser_sel <= srsg_pkg::LASER_MAX_CODE) ?
                      laser_sel[1:0] : 2'd0;
    r.sample_out    = smp;
    r.column        = col_at;
    r.row_end       = (int'(col_at) + 1 >= cols);
    r.y_position    = '0;
    if (r.row_end) begin
      col_at       = '0;
      next_row     = (int'(row_at) + 1 >= rows) ? 0 : int'(row_at) + 1;
      row_at       = srsg_pkg::CNT_W'(next_row);
      r.y_position = y_mid + step_offset(row_at, rows);
    end else begin
      col_at = col_at + 1'b1;
    end
    r.y_drive_valid = r.row_end & scan_on;
    r.row           = row_at;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driving tasks (all inputs change on the falling edge)
  // --------------------------------------------------------------------------

  // register write; size writes restart the scan at column 0, row 0
  task automatic write_reg(input logic [srsg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srsg_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      srsg_pkg::REG_COLUMNS_PER_ROW: begin
        cols_set = data[srsg_pkg::SIZE_W-1:0];
        col_at   = '0;
        row_at   = '0;
      end
      srsg_pkg::REG_ROWS_PER_FRAME: begin
        rows_set = data[srsg_pkg::SIZE_W-1:0];
        col_at   = '0;
        row_at   = '0;
      end
      srsg_pkg::REG_X_CENTER:     x_mid      = data;
      srsg_pkg::REG_Y_CENTER:     y_mid      = data;
      srsg_pkg::REG_STEP_SIZE:    step_units = data[srsg_pkg::STEP_W-1:0];
      srsg_pkg::REG_SCAN_ENABLE:  scan_on    = data[0];
      srsg_pkg::REG_LASER_CHOICE: laser_sel  = data[srsg_pkg::LASER_W-1:0];
      default: ;
    endcase
  endtask

  // one x-step request; valid stays up after acceptance so that a following
  // call with no gap runs back to back
  task automatic send_sample(input logic [srsg_pkg::SAMPLE_W-1:0] smp);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    in_sample = smp;
    do @(posedge clk); while (in_stall);
    raster_due.push_back(advance_raster(smp));
    samples_sent++;
  endtask

  // random sample value
  function automatic logic [srsg_pkg::SAMPLE_W-1:0] rand_sample();
    return srsg_pkg::SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  // drop valid, wait for every predicted result, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (raster_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result sink: random stalls per result plus an optional long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    out_stall = 1'b0;
    rx_wait   = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) rx_wait = $urandom_range(0, rx_max);
      if (rx_hold_id != hold_seen) begin
        hold_seen = rx_hold_id;
        hold_left = rx_hold;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = (rx_wait > 0);
        if (rx_wait > 0) rx_wait--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string what,
                             input logic [srsg_pkg::POS_W-1:0] want,
                             input logic [srsg_pkg::POS_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s, result %0d: expected %0h, got %0h",
                 what, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    srsg_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (raster_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: column %0d row %0d", out_column, out_row);
      end else begin
        want = raster_due.pop_front();
        check_field("x_position", want.x_position, out_x_position);
        check_field("x_drive_valid", srsg_pkg::POS_W'(want.x_drive_valid),
                    srsg_pkg::POS_W'(out_x_drive_valid));
        check_field("laser_drive", srsg_pkg::POS_W'(want.laser_drive),
                    srsg_pkg::POS_W'(out_laser_drive));
        check_field("sample_out", srsg_pkg::POS_W'(want.sample_out),
                    srsg_pkg::POS_W'(out_sample_out));
        check_field("column", srsg_pkg::POS_W'(want.column),
                    srsg_pkg::POS_W'(out_column));
        check_field("row_end", srsg_pkg::POS_W'(want.row_end),
                    srsg_pkg::POS_W'(out_row_end));
        check_field("y_position", want.y_position, out_y_position);
        check_field("y_drive_valid", srsg_pkg::POS_W'(want.y_drive_valid),
                    srsg_pkg::POS_W'(out_y_drive_valid));
        check_field("row", srsg_pkg::POS_W'(want.row), srsg_pkg::POS_W'(out_row));
        if (want.row_end) row_ends_seen++;
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // power-up register values, sample extremes, back to back
  task automatic test_reset_defaults();
    tx_max = 0;
    rx_max = 0;
    send_sample('0);
    send_sample('1);
    send_sample(10'h2AA);
    send_sample(10'h155);
    repeat (4) send_sample(rand_sample());
  endtask

  // short rows: mirrored x on odd rows, row and frame wrap, 16-bit overflow
  task automatic test_mirror_and_wrap();
    settle();
    write_reg(srsg_pkg::REG_COLUMNS_PER_ROW, 16'd6);
    write_reg(srsg_pkg::REG_ROWS_PER_FRAME,  16'd2);
    write_reg(srsg_pkg::REG_X_CENTER,        16'hFFFF);
    write_reg(srsg_pkg::REG_Y_CENTER,        16'hFFFF);
    write_reg(srsg_pkg::REG_STEP_SIZE,       16'd255);
    write_reg(srsg_pkg::REG_SCAN_ENABLE,     16'd1);
    write_reg(srsg_pkg::REG_LASER_CHOICE,    16'd3);
    tx_max = 18;
    rx_max = 18;
    repeat (12) send_sample(rand_sample());
  endtask

  // zero sizes act as one, masked and saturated sizes, laser codes past the largest
  task automatic test_size_edges();
    settle();
    write_reg(srsg_pkg::REG_COLUMNS_PER_ROW, 16'd0);
    write_reg(srsg_pkg::REG_ROWS_PER_FRAME,  16'd0);
    write_reg(srsg_pkg::REG_X_CENTER,        16'd0);
    write_reg(srsg_pkg::REG_STEP_SIZE,       16'd0);
    write_reg(srsg_pkg::REG_LASER_CHOICE,    16'd4);
    tx_max = 4;
    rx_max = 4;
    repeat (3) send_sample(rand_sample());
    settle();
    write_reg(srsg_pkg::REG_COLUMNS_PER_ROW, 16'hF803);   // upper bits dropped: 3
    write_reg(srsg_pkg::REG_ROWS_PER_FRAME,  16'hFFFF);   // 2047 clamps to max
    write_reg(srsg_pkg::REG_STEP_SIZE,       16'd200);
    write_reg(srsg_pkg::REG_SCAN_ENABLE,     16'd0);
    write_reg(srsg_pkg::REG_LASER_CHOICE,    16'd255);
    repeat (4) send_sample(rand_sample());
  endtask

  // one full row at the largest size, then into the next row
  task automatic test_full_row_sweep();
    settle();
    write_reg(srsg_pkg::REG_COLUMNS_PER_ROW, 16'd2047);
    write_reg(srsg_pkg::REG_ROWS_PER_FRAME,  16'd2);
    write_reg(srsg_pkg::REG_X_CENTER,        16'($urandom_range(0, 65535)));
    write_reg(srsg_pkg::REG_STEP_SIZE,       16'($urandom_range(1, 255)));
    write_reg(srsg_pkg::REG_SCAN_ENABLE,     16'd1);
    write_reg(srsg_pkg::REG_LASER_CHOICE,    16'd2);
    tx_max = 0;
    rx_max = 0;
    repeat (500) send_sample(rand_sample());
    tx_max = 3;
    rx_max = 3;
    repeat (530) send_sample(rand_sample());
  endtask

  // receiver holds off long enough to fill the pipe and stall the input,
  // then the sender pauses until all results are back
  task automatic test_backpressure();
    settle();
    write_reg(srsg_pkg::REG_COLUMNS_PER_ROW, 16'd5);
    write_reg(srsg_pkg::REG_ROWS_PER_FRAME,  16'd3);
    write_reg(srsg_pkg::REG_LASER_CHOICE,    16'd1);
    tx_max  = 0;
    rx_max  = 0;
    rx_hold = 150;
    rx_hold_id++;
    repeat (24) send_sample(rand_sample());
    settle();
    tx_max  = 18;
    rx_hold = 60;
    rx_hold_id++;
    repeat (10) send_sample(rand_sample());
  endtask

  function automatic logic [srsg_pkg::CFG_DAT_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return srsg_pkg::CFG_DAT_W'($urandom_range(1025, 2047));
      2:       return srsg_pkg::CFG_DAT_W'($urandom_range(0, 65535));
      default: return srsg_pkg::CFG_DAT_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic int rand_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  // random settings per phase; sizes are sometimes left alone so the scan
  // carries on across phases
  task automatic test_random_scans();
    int n;
    repeat (8) begin
      settle();
      tx_max = rand_limit();
      rx_max = rand_limit();
      if ($urandom_range(0, 2) != 0)
        write_reg(srsg_pkg::REG_COLUMNS_PER_ROW, rand_size());
      if ($urandom_range(0, 2) != 0)
        write_reg(srsg_pkg::REG_ROWS_PER_FRAME, rand_size());
      if ($urandom_range(0, 1) != 0)
        write_reg(srsg_pkg::REG_X_CENTER, srsg_pkg::CFG_DAT_W'($urandom_range(0, 65535)));
      if ($urandom_range(0, 1) != 0)
        write_reg(srsg_pkg::REG_Y_CENTER, srsg_pkg::CFG_DAT_W'($urandom_range(0, 65535)));
      if ($urandom_range(0, 1) != 0)
        write_reg(srsg_pkg::REG_STEP_SIZE, srsg_pkg::CFG_DAT_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0)
        write_reg(srsg_pkg::REG_SCAN_ENABLE, srsg_pkg::CFG_DAT_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) != 0)
        write_reg(srsg_pkg::REG_LASER_CHOICE, ($urandom_range(0, 3) == 0) ?
                  srsg_pkg::CFG_DAT_W'($urandom_range(0, 255)) :
                  srsg_pkg::CFG_DAT_W'($urandom_range(0, 3)));
      n = $urandom_range(10, 30);
      repeat (n) send_sample(rand_sample());
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = srsg_pkg::REG_COLUMNS_PER_ROW;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_sample      = '0;
    tx_max         = 0;
    rx_max         = 0;
    rx_hold        = 0;
    rx_hold_id     = 0;
    samples_sent   = 0;
    results_seen   = 0;
    row_ends_seen  = 0;
    mismatch_count = 0;
    // power-up values of the block
    cols_set   = srsg_pkg::SIZE_W'(216);
    rows_set   = srsg_pkg::SIZE_W'(216);
    x_mid      = 16'd2170;
    y_mid      = 16'd2050;
    step_units = 8'd8;
    scan_on    = 1'b0;
    laser_sel  = '0;
    col_at     = '0;
    row_at     = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_mirror_and_wrap();
    test_size_edges();
    test_full_row_sweep();
    test_backpressure();
    test_random_scans();
    settle();
    repeat (10) @(posedge clk);

    $display("ran %0d x-step requests, %0d results checked, %0d row ends",
             samples_sent, results_seen, row_ends_seen);
    $display("sizes from zero to clamped, mirrored rows, all laser codes, long stalls");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", raster_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
